// ===== hdl/tmmc_pkg.sv =====
// Shared types and constants for the trimmed mean mode classifier.
package tmmc_pkg;

  localparam int ADC_BITS_DEF = 10;
  localparam int GROUP_SIZE   = 6;
  localparam int ROUND_BIAS   = 2;
  localparam int COUNT_W      = 3;

  localparam int WINDOW_RST = 50;
  localparam int CONT_RST   = 341;
  localparam int INTER_RST  = 682;
  localparam int SLEEP_RST  = 1023;

  typedef enum logic [1:0] {
    MODE_DISABLED = 2'd0,
    MODE_CONT     = 2'd1,
    MODE_INTER    = 2'd2,
    MODE_DORMANT  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_WINDOW = 2'd0,
    REG_CONT   = 2'd1,
    REG_INTER  = 2'd2,
    REG_SLEEP  = 2'd3
  } reg_idx_e;

endpackage

// ===== hdl/tmmc_accum.sv =====
// Six-sample group accumulator producing the rounded trimmed mean.
module tmmc_accum #(
  parameter int ADC_BITS = tmmc_pkg::ADC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ADC_BITS-1:0] sample_i,
  input  logic                lvl_ready_i,
  output logic                lvl_valid_o,
  output logic [ADC_BITS-1:0] lvl_o
);
  import tmmc_pkg::*;

  localparam int SUM_W = ADC_BITS + 3;

  logic [COUNT_W-1:0]  count_q, count_d;
  logic [ADC_BITS-1:0] min_q, min_d;
  logic [ADC_BITS-1:0] max_q, max_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic                lvl_valid_q, lvl_valid_d;
  logic [ADC_BITS-1:0] lvl_q;

  logic                in_accept;
  logic                last;
  logic [ADC_BITS-1:0] min_n, max_n;
  logic [SUM_W-1:0]    sum_n, trim;

  assign in_stall_o = lvl_valid_q && !lvl_ready_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign last       = (count_q == COUNT_W'(GROUP_SIZE - 1));

  assign min_n = (sample_i < min_q) ? sample_i : min_q;
  assign max_n = (sample_i > max_q) ? sample_i : max_q;
  assign sum_n = sum_q + SUM_W'(sample_i);
  // Drop the extremes and round the mean of the remaining four.
  assign trim  = sum_n - SUM_W'(min_n) - SUM_W'(max_n) + SUM_W'(ROUND_BIAS);

  always_comb begin
    count_d     = count_q;
    min_d       = min_q;
    max_d       = max_q;
    sum_d       = sum_q;
    lvl_valid_d = lvl_valid_q;
    if (in_accept) begin
      lvl_valid_d = last;
      if (last) begin
        count_d = '0;
        min_d   = '1;
        max_d   = '0;
        sum_d   = '0;
      end else begin
        count_d = count_q + COUNT_W'(1);
        min_d   = min_n;
        max_d   = max_n;
        sum_d   = sum_n;
      end
    end else if (lvl_ready_i) begin
      lvl_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      min_q       <= '1;
      max_q       <= '0;
      sum_q       <= '0;
      lvl_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      min_q       <= min_d;
      max_q       <= max_d;
      sum_q       <= sum_d;
      lvl_valid_q <= lvl_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && last) begin
      lvl_q <= trim[ADC_BITS+1:2];
    end
  end

  assign lvl_valid_o = lvl_valid_q;
  assign lvl_o       = lvl_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(GROUP_SIZE - 1))
    else $error("group counter ran past the group size");

  a_group_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && last) |=> (lvl_valid_q && count_q == '0 && sum_q == '0 && min_q == '1))
    else $error("group end did not issue a level and clear the group");

  a_level_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lvl_valid_q && !lvl_ready_i) |=> (lvl_valid_q && $stable(lvl_q)))
    else $error("waiting level changed before it was taken");

endmodule

// ===== hdl/tmmc_classify.sv =====
// Mode decision on the trimmed mean and the result register.
module tmmc_classify #(
  parameter int ADC_BITS = tmmc_pkg::ADC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                lvl_valid_i,
  output logic                lvl_ready_o,
  input  logic [ADC_BITS-1:0] lvl_i,
  input  logic [ADC_BITS-1:0] window_i,
  input  logic [ADC_BITS-1:0] cont_center_i,
  input  logic [ADC_BITS-1:0] inter_center_i,
  input  logic [ADC_BITS-1:0] sleep_level_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tmmc_pkg::mode_e     mode_o,
  output logic [ADC_BITS-1:0] level_o,
  output logic                matched_o
);
  import tmmc_pkg::*;

  localparam int DW = ADC_BITS + 1;

  logic                out_valid_q, out_valid_d;
  mode_e               mode_q, mode_d;
  logic [ADC_BITS-1:0] level_q;
  logic                matched_q, matched_d;
  logic                fire;

  logic signed [DW-1:0] lvl_s, win_s, d_cont, d_inter, a_cont, a_inter, sleep_thr;

  assign lvl_ready_o = !out_valid_q || !out_stall_i;
  assign fire        = lvl_valid_i && lvl_ready_o;

  assign lvl_s     = signed'({1'b0, lvl_i});
  assign win_s     = signed'({1'b0, window_i});
  assign d_cont    = lvl_s - signed'({1'b0, cont_center_i});
  assign d_inter   = lvl_s - signed'({1'b0, inter_center_i});
  assign a_cont    = d_cont[DW-1] ? -d_cont : d_cont;
  assign a_inter   = d_inter[DW-1] ? -d_inter : d_inter;
  assign sleep_thr = signed'({1'b0, sleep_level_i}) - win_s;

  always_comb begin
    mode_d      = mode_q;
    matched_d   = matched_q;
    out_valid_d = out_valid_q;
    if (lvl_ready_o) begin
      out_valid_d = lvl_valid_i;
    end
    if (fire) begin
      matched_d = 1'b1;
      // First window in priority order wins; otherwise hold the mode.
      if (lvl_i <= window_i) begin
        mode_d = MODE_DISABLED;
      end else if (a_cont <= win_s) begin
        mode_d = MODE_CONT;
      end else if (a_inter <= win_s) begin
        mode_d = MODE_INTER;
      end else if (lvl_s >= sleep_thr) begin
        mode_d = MODE_DORMANT;
      end else begin
        matched_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      mode_q      <= MODE_DISABLED;
      matched_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      mode_q      <= mode_d;
      matched_q   <= matched_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      level_q <= lvl_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign mode_o      = mode_q;
  assign level_o     = level_q;
  assign matched_o   = matched_q;

  a_fire_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("accepted level did not reach the result register");

  a_off_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && lvl_i <= window_i) |=> (mode_q == MODE_DISABLED && matched_q))
    else $error("level inside the off window did not select off");

  a_hold_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(mode_q))
    else $error("mode changed without a new level");

endmodule

// ===== hdl/trimmed_mean_mode_classifier.sv =====
// Top level of the trimmed mean mode classifier: config registers and datapath.
//
// Usage:
//   Input channel: sample_i with in_valid_i / in_stall_o. A transaction is
//   accepted at a clock edge with in_valid_i high and in_stall_o low.
//   Every sixth accepted sample closes a group and yields one result
//   transaction on mode_o / level_o / matched_o with out_valid_o /
//   out_stall_i; the other five samples yield nothing.
//   Throughput: one sample per cycle while in_stall_o is low. The level
//   register loads at the edge that accepts the sixth sample; the result
//   register then takes that level once out_valid_o or out_stall_i is low,
//   and out_valid_o rises as it loads.
//   Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (window, continuous center, intermittent center, sleep level) at the
//   clock edge; write only while no group result is pending.
//   Reset (rst_ni low, asynchronous): config returns to its defaults, the
//   group restarts empty and the mode goes to off.
//   Stall: a result held by out_stall_i stays stable; samples keep being
//   accepted until a second finished level waits behind it, then
//   in_stall_o rises until the result is taken.
module trimmed_mean_mode_classifier #(
  parameter int ADC_BITS = tmmc_pkg::ADC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  tmmc_pkg::reg_idx_e  cfg_idx_i,
  input  logic [ADC_BITS-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ADC_BITS-1:0] sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tmmc_pkg::mode_e     mode_o,
  output logic [ADC_BITS-1:0] level_o,
  output logic                matched_o
);
  import tmmc_pkg::*;

  logic [ADC_BITS-1:0] window_q, cont_q, inter_q, sleep_q;
  logic                lvl_valid, lvl_ready;
  logic [ADC_BITS-1:0] lvl;

  // Config registers; defaults truncate to the ADC width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= ADC_BITS'(WINDOW_RST);
      cont_q   <= ADC_BITS'(CONT_RST);
      inter_q  <= ADC_BITS'(INTER_RST);
      sleep_q  <= ADC_BITS'(SLEEP_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WINDOW: window_q <= cfg_data_i;
        REG_CONT:   cont_q   <= cfg_data_i;
        REG_INTER:  inter_q  <= cfg_data_i;
        REG_SLEEP:  sleep_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Accumulate groups of six and produce the trimmed mean.
  tmmc_accum #(.ADC_BITS(ADC_BITS)) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .lvl_ready_i (lvl_ready),
    .lvl_valid_o (lvl_valid),
    .lvl_o       (lvl)
  );

  // Classify the mean and hold the result for the receiver.
  tmmc_classify #(.ADC_BITS(ADC_BITS)) u_classify (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .lvl_valid_i    (lvl_valid),
    .lvl_ready_o    (lvl_ready),
    .lvl_i          (lvl),
    .window_i       (window_q),
    .cont_center_i  (cont_q),
    .inter_center_i (inter_q),
    .sleep_level_i  (sleep_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mode_o         (mode_o),
    .level_o        (level_o),
    .matched_o      (matched_o)
  );

endmodule
